/* rtl/core/crc8fd_pkg.sv */
// Shared types, constants and the CRC-8 byte update for the frame decoder.
// No dependencies; every module of the decoder imports this package.
package crc8fd_pkg;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] CRC_TOPBIT = 8'h80;

	localparam logic [7:0]  SYNC_RESET   = 8'hA5;
	localparam logic [7:0]  TYPE_A_RESET = 8'h01;
	localparam logic [7:0]  TYPE_B_RESET = 8'h02;
	localparam logic [15:0] MAX_PL_RESET = 16'd1024;

	typedef enum logic [1:0] {
		REG_SYNC_BYTE     = 2'd0,
		REG_TYPE_A        = 2'd1,
		REG_TYPE_B        = 2'd2,
		REG_PAYLOAD_LIMIT = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IGNORED = 3'd0,
		ST_HEADER  = 3'd1,
		ST_PAYLOAD = 3'd2,
		ST_GOOD    = 3'd3,
		ST_CRCBAD  = 3'd4,
		ST_TYPEREJ = 3'd5,
		ST_LENREJ  = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0]  sync_byte;
		logic [7:0]  accepted_type_a;
		logic [7:0]  accepted_type_b;
		logic [15:0] payload_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
	} in_word_t;

	typedef struct packed {
		status_t     status;
		logic        resynced;
		logic [7:0]  payload_byte;
		logic [15:0] payload_index;
		logic [7:0]  frame_type;
		logic [15:0] frame_length;
		logic [31:0] bad_count;
		logic [31:0] good_count;
	} out_word_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data_byte;
	} stage_t;

	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_TOPBIT) != 8'd0) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* rtl/core/crc8fd_stream_if.sv */
// Valid/ready stream channel carrying one word of a given payload type.
// Depends on nothing; the payload type comes from crc8fd_pkg at instantiation.
interface crc8fd_stream_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/crc8fd_cfg.sv */
// APB-style configuration registers of the frame decoder.
// Depends on crc8fd_pkg for the register map and the configuration struct.
module crc8fd_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crc8fd_pkg::ADDR_W-1:0] paddr,
	input  logic [crc8fd_pkg::DATA_W-1:0] pwdata,
	output logic [crc8fd_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	output crc8fd_pkg::cfg_t              cfg
);
	import crc8fd_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_byte       <= SYNC_RESET;
			cfg_q.accepted_type_a <= TYPE_A_RESET;
			cfg_q.accepted_type_b <= TYPE_B_RESET;
			cfg_q.payload_limit   <= MAX_PL_RESET;
		end else if (wr_en) begin
			unique case (idx)
				REG_SYNC_BYTE:     cfg_q.sync_byte       <= pwdata[7:0];
				REG_TYPE_A:        cfg_q.accepted_type_a <= pwdata[7:0];
				REG_TYPE_B:        cfg_q.accepted_type_b <= pwdata[7:0];
				REG_PAYLOAD_LIMIT: cfg_q.payload_limit   <= pwdata[15:0];
				default:           cfg_q.sync_byte       <= cfg_q.sync_byte;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SYNC_BYTE:     prdata = {24'd0, cfg_q.sync_byte};
			REG_TYPE_A:        prdata = {24'd0, cfg_q.accepted_type_a};
			REG_TYPE_B:        prdata = {24'd0, cfg_q.accepted_type_b};
			REG_PAYLOAD_LIMIT: prdata = {16'd0, cfg_q.payload_limit};
			default:           prdata = '0;
		endcase
	end

endmodule

/* rtl/core/crc8fd_in_stage.sv */
// Input register of the frame decoder: captures one received byte per word.
// Depends on crc8fd_pkg and crc8fd_stream_if.
module crc8fd_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	crc8fd_stream_if.sink      rx,
	input  logic               advance,
	output crc8fd_pkg::stage_t stage
);
	import crc8fd_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign rx.ready        = !valid_s1 || advance;
	assign stage.valid     = valid_s1;
	assign stage.data_byte = byte_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.data.data_byte;
		end
	end

endmodule

/* rtl/core/crc8fd_core.sv */
// Frame parser state, CRC accumulation, counters and the result register.
// Depends on crc8fd_pkg and crc8fd_stream_if.
module crc8fd_core (
	input  logic               clk,
	input  logic               arst_n,
	input  crc8fd_pkg::cfg_t   cfg,
	input  crc8fd_pkg::stage_t stage,
	output logic               advance,
	crc8fd_stream_if.source    res
);
	import crc8fd_pkg::*;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_TYPE,
		PH_LEN0,
		PH_LEN1,
		PH_PAYLOAD,
		PH_CRC
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  type_q, type_d;
	logic [15:0] len_q, len_d;
	logic [15:0] rcvd_q, rcvd_d;
	logic [7:0]  crc_q, crc_d;
	logic [31:0] bad_q, bad_d;
	logic [31:0] good_q, good_d;
	logic        out_valid_q;
	out_word_t   result_q, result_d;

	logic [7:0]  b;
	logic [15:0] new_len;
	logic [15:0] rcvd_inc;
	logic        is_sync;
	logic [7:0]  crc_base;
	logic [7:0]  crc_next;

	assign advance   = stage.valid && (!out_valid_q || res.ready);
	assign res.valid = out_valid_q;
	assign res.data  = result_q;

	assign b        = stage.data_byte;
	assign is_sync  = (b == cfg.sync_byte);
	assign new_len  = {b, len_q[7:0]};
	assign rcvd_inc = rcvd_q + 16'd1;
	assign crc_base = (phase_q == PH_TYPE) ? 8'd0 : crc_q;
	assign crc_next = crc8_update(crc_base, b);

	always_comb begin
		phase_d  = phase_q;
		type_d   = type_q;
		len_d    = len_q;
		rcvd_d   = rcvd_q;
		crc_d    = crc_q;
		bad_d    = bad_q;
		good_d   = good_q;
		result_d = '0;
		result_d.status = ST_IGNORED;
		unique case (phase_q)
			PH_HUNT: begin
				phase_d         = is_sync ? PH_TYPE : PH_HUNT;
				result_d.status = is_sync ? ST_HEADER : ST_IGNORED;
			end
			PH_TYPE: begin
				if (b != cfg.accepted_type_a && b != cfg.accepted_type_b) begin
					bad_d             = bad_q + 32'd1;
					result_d.status   = ST_TYPEREJ;
					result_d.resynced = is_sync;
					phase_d           = is_sync ? PH_TYPE : PH_HUNT;
				end else begin
					type_d          = b;
					crc_d           = crc_next;
					phase_d         = PH_LEN0;
					result_d.status = ST_HEADER;
				end
			end
			PH_LEN0: begin
				len_d           = {8'd0, b};
				crc_d           = crc_next;
				phase_d         = PH_LEN1;
				result_d.status = ST_HEADER;
			end
			PH_LEN1: begin
				len_d = new_len;
				if (new_len > cfg.payload_limit) begin
					bad_d             = bad_q + 32'd1;
					result_d.status   = ST_LENREJ;
					result_d.resynced = is_sync;
					phase_d           = is_sync ? PH_TYPE : PH_HUNT;
				end else begin
					crc_d           = crc_next;
					rcvd_d          = 16'd0;
					phase_d         = (new_len != 16'd0) ? PH_PAYLOAD : PH_CRC;
					result_d.status = ST_HEADER;
				end
			end
			PH_PAYLOAD: begin
				result_d.payload_byte  = b;
				result_d.payload_index = rcvd_q;
				rcvd_d                 = rcvd_inc;
				crc_d                  = crc_next;
				if (rcvd_inc == len_q) begin
					phase_d = PH_CRC;
				end
				result_d.status = ST_PAYLOAD;
			end
			PH_CRC: begin
				phase_d = PH_HUNT;
				if (b != crc_q) begin
					bad_d           = bad_q + 32'd1;
					result_d.status = ST_CRCBAD;
				end else begin
					good_d          = good_q + 32'd1;
					result_d.status = ST_GOOD;
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
		result_d.frame_type   = type_d;
		result_d.frame_length = len_d;
		result_d.bad_count    = bad_d;
		result_d.good_count   = good_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			type_q      <= 8'd0;
			len_q       <= 16'd0;
			rcvd_q      <= 16'd0;
			crc_q       <= 8'd0;
			bad_q       <= 32'd0;
			good_q      <= 32'd0;
			out_valid_q <= 1'b0;
			result_q    <= '0;
		end else if (advance) begin
			phase_q     <= phase_d;
			type_q      <= type_d;
			len_q       <= len_d;
			rcvd_q      <= rcvd_d;
			crc_q       <= crc_d;
			bad_q       <= bad_d;
			good_q      <= good_d;
			out_valid_q <= 1'b1;
			result_q    <= result_d;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

/* rtl/core/crc8_frame_decoder.sv */
// Top level of the sync/type/length frame decoder with CRC-8 check.
// Depends on crc8fd_pkg, crc8fd_stream_if, crc8fd_cfg, crc8fd_in_stage, crc8fd_core.
//
//   channel  dir  word          content
//   rx       in   in_word_t     one received link byte
//   res      out  out_word_t    status, payload byte and index, frame info, counters
//   apb      in   32-bit data   sync byte, two type codes, maximum payload
//
// One byte is taken per cycle while the result is not stalled; its result is offered
// once the input register has passed it to the result register.
// The CRC-8 update and the parser state advance together in the same cycle.
// arst_n clears the parser state, the counters and both valid flags at once.
// A stalled result holds the input register, which then holds rx.ready low.
module crc8_frame_decoder (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [crc8fd_pkg::ADDR_W-1:0] paddr,
	input  logic [crc8fd_pkg::DATA_W-1:0] pwdata,
	output logic [crc8fd_pkg::DATA_W-1:0] prdata,
	output logic                          pready,
	crc8fd_stream_if.sink                 rx,
	crc8fd_stream_if.source               res
);
	import crc8fd_pkg::*;

	cfg_t   cfg;
	stage_t stage;
	logic   advance;

	crc8fd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crc8fd_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.stage   (stage)
	);

	crc8fd_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.stage   (stage),
		.advance (advance),
		.res     (res)
	);

endmodule
